@@ rtl/core/qrbv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qrbv_pkg
// Shared types and codes for the ordered queue with remove-by-value.
// ----------------------------------------------------------------------------
package qrbv_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int ACT_W = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  // action codes; the fourth code has no meaning and is ignored
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_SHIFT,
    S_RD_ISSUE,
    S_RD_DATA,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted word, rewind the scan pointer
    logic step;    // issue the next sequential read
    logic shift;   // with step: write back one place toward the head
    logic seek;    // restart reading just after the matching entry
    logic append;  // write at the tail and grow
    logic dec;     // shrink by one
    logic rd_pos;  // read at the requested position
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_ok;  // scan pointer below the count
    logic pend_v;    // read data for a scanned entry arrives this cycle
    logic match;     // that entry equals the captured value
    logic full;
    logic pos_ok;
  } sts_t;

  typedef struct packed {
    logic    load;
    status_t status;
    logic    use_rd;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/qrbv_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qrbv_in_if
// Request channel: valid/ready with action, value and position.
// ----------------------------------------------------------------------------
interface qrbv_in_if;
  logic                         valid;
  logic                         ready;
  logic [qrbv_pkg::ACT_W-1:0]   action;
  logic [qrbv_pkg::VAL_W-1:0]   value;
  logic [qrbv_pkg::POS_W-1:0]   position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface
`default_nettype wire

@@ rtl/core/qrbv_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qrbv_out_if
// Response channel: valid/ready with read value, entry count and status.
// ----------------------------------------------------------------------------
interface qrbv_out_if;
  logic                         valid;
  logic                         ready;
  logic [qrbv_pkg::VAL_W-1:0]   read_value;
  logic [qrbv_pkg::CNT_W-1:0]   entry_count;
  logic [1:0]                   status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input entry_count, input status,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/queue_remove_by_value_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// queue_remove_by_value_core
// Ordered queue of identifiers with append, remove-first-match and read.
// ----------------------------------------------------------------------------
// Requests arrive on req (action, value, position); every request gives one
// word on rsp carrying the read value, the entry count after the request and
// a status code. One request is worked on at a time; req is ready only while
// the sequencer is idle, and the next request can be taken in the cycle after
// the response is loaded.
// States from acceptance to the response being loaded:
//   append            S_APPEND, S_RESP
//   read              S_RD_ISSUE, S_RD_DATA, S_RESP (S_RD_ISSUE, S_RESP if beyond the count)
//   unused action     S_RESP
//   remove, no match  S_SCAN, S_RESP
//   remove, match     S_SCAN, S_SHIFT, S_RESP
// The remove scan and the close-up shift each stream one entry per cycle
// through the single read port of the entry RAM. The response sits in an
// output register, so a stalled receiver costs nothing until the next
// request finishes; that request then waits in the sequencer until rsp is
// taken. Reset empties the queue at once; the RAM itself needs no clearing,
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
module queue_remove_by_value_core #(
  parameter int DEPTH = qrbv_pkg::DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  qrbv_in_if.sink     req,
  qrbv_out_if.source  rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  qrbv_pkg::cmd_t cmd;
  qrbv_pkg::sts_t sts;
  qrbv_pkg::res_t res;
  logic [CW-1:0]  fill;
  logic           req_ready;
  logic           rsp_valid;

  qrbv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req_ready),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp_valid),
    .sts        (sts),
    .cmd        (cmd),
    .res        (res)
  );

  qrbv_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .res          (res),
    .req_value    (req.value),
    .req_position (req.position),
    .sts          (sts),
    .fill         (fill),
    .read_value   (rsp.read_value),
    .entry_count  (rsp.entry_count),
    .status       (rsp.status)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  // the count never passes the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("entry count above capacity");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in flight");

  // a full status comes only with the count at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == qrbv_pkg::ST_FULL) |->
      rsp.entry_count == qrbv_pkg::CNT_W'(DEPTH))
    else $error("full status with spare room");

  // only a successful read carries a value
  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.read_value != '0) |-> rsp.status == qrbv_pkg::ST_OK)
    else $error("read value on a failed request");

endmodule
`default_nettype wire

@@ rtl/core/qrbv_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qrbv_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qrbv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/qrbv_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qrbv_datapath
// Entry storage, count, scan pointer, compare and result register.
// ----------------------------------------------------------------------------
module qrbv_datapath #(
  parameter int DEPTH = qrbv_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire qrbv_pkg::cmd_t               cmd,
  input  wire qrbv_pkg::res_t               res,
  input  wire logic [qrbv_pkg::VAL_W-1:0]   req_value,
  input  wire logic [qrbv_pkg::POS_W-1:0]   req_position,
  output qrbv_pkg::sts_t                    sts,
  output logic [CW-1:0]                     fill,
  output logic [qrbv_pkg::VAL_W-1:0]        read_value,
  output logic [qrbv_pkg::CNT_W-1:0]        entry_count,
  output logic [1:0]                        status
);

  logic [CW-1:0]               count;
  logic [CW-1:0]               ptr;
  logic [AW-1:0]               pend;
  logic                        pend_v;
  logic [qrbv_pkg::VAL_W-1:0]  value_q;
  logic [qrbv_pkg::POS_W-1:0]  pos_q;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [qrbv_pkg::VAL_W-1:0]  wdata;
  logic                        re;
  logic [AW-1:0]               raddr;
  logic [qrbv_pkg::VAL_W-1:0]  rdata;

  qrbv_ram #(
    .WIDTH (qrbv_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.issue_ok = (ptr < count);
    sts.pend_v   = pend_v;
    sts.match    = pend_v && (rdata == value_q);
    sts.full     = (count == CW'(DEPTH));
    sts.pos_ok   = (32'(pos_q) < 32'(count));
  end

  // one read port serves the scan, the shift and positional reads
  always_comb begin
    re    = 1'b0;
    raddr = ptr[AW-1:0];
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = value_q;
    if (cmd.step && sts.issue_ok) begin
      re = 1'b1;
    end
    if (cmd.rd_pos) begin
      re    = 1'b1;
      raddr = AW'(pos_q);
    end
    if (cmd.append) begin
      we = 1'b1;
    end
    // the word read last cycle moves one place toward the head
    if (cmd.step && cmd.shift && pend_v) begin
      we    = 1'b1;
      waddr = pend - AW'(1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ptr    <= '0;
      pend_v <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr    <= '0;
        pend_v <= 1'b0;
      end else if (cmd.seek) begin
        ptr    <= CW'(pend) + CW'(1);
        pend_v <= 1'b0;
      end else if (cmd.step) begin
        if (sts.issue_ok) begin
          ptr    <= ptr + CW'(1);
          pend_v <= 1'b1;
        end else begin
          pend_v <= 1'b0;
        end
      end
      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.dec) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= req_value;
      pos_q   <= req_position;
    end
    if (cmd.step && sts.issue_ok) begin
      pend <= ptr[AW-1:0];
    end
    if (res.load) begin
      read_value  <= res.use_rd ? rdata : '0;
      entry_count <= qrbv_pkg::CNT_W'(count);
      status      <= res.status;
    end
  end

  assign fill = count;

endmodule
`default_nettype wire

@@ rtl/core/qrbv_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qrbv_ctrl
// Sequencer: takes one word, steps the datapath through it, issues the result.
// ----------------------------------------------------------------------------
module qrbv_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  input  wire logic [qrbv_pkg::ACT_W-1:0]   req_action,
  output logic                              req_ready,
  input  wire logic                         rsp_ready,
  output logic                              rsp_valid,
  input  wire qrbv_pkg::sts_t               sts,
  output qrbv_pkg::cmd_t                    cmd,
  output qrbv_pkg::res_t                    res
);

  qrbv_pkg::state_t  state, state_next;
  qrbv_pkg::status_t stat, stat_next;
  logic              use_rd, use_rd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qrbv_pkg::S_IDLE;
      stat      <= qrbv_pkg::ST_OK;
      use_rd    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      stat   <= stat_next;
      use_rd <= use_rd_next;
      if (res.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    stat_next   = stat;
    use_rd_next = use_rd;
    cmd         = '0;
    res.load    = 1'b0;
    res.status  = stat;
    res.use_rd  = use_rd;
    req_ready   = 1'b0;
    unique case (state)
      qrbv_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load    = 1'b1;
          stat_next   = qrbv_pkg::ST_OK;
          use_rd_next = 1'b0;
          unique case (req_action)
            qrbv_pkg::ACT_APPEND: state_next = qrbv_pkg::S_APPEND;
            qrbv_pkg::ACT_REMOVE: state_next = qrbv_pkg::S_SCAN;
            qrbv_pkg::ACT_READ:   state_next = qrbv_pkg::S_RD_ISSUE;
            default:              state_next = qrbv_pkg::S_RESP;
          endcase
        end
      end
      qrbv_pkg::S_APPEND: begin
        if (sts.full) begin
          stat_next = qrbv_pkg::ST_FULL;
        end else begin
          cmd.append = 1'b1;
        end
        state_next = qrbv_pkg::S_RESP;
      end
      qrbv_pkg::S_SCAN: begin
        if (sts.match) begin
          cmd.seek   = 1'b1;
          state_next = qrbv_pkg::S_SHIFT;
        end else if (!sts.pend_v && !sts.issue_ok) begin
          stat_next  = qrbv_pkg::ST_NOTFOUND;
          state_next = qrbv_pkg::S_RESP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      qrbv_pkg::S_SHIFT: begin
        // drain: last word written back and nothing left to read
        if (!sts.pend_v && !sts.issue_ok) begin
          cmd.dec    = 1'b1;
          state_next = qrbv_pkg::S_RESP;
        end else begin
          cmd.step  = 1'b1;
          cmd.shift = 1'b1;
        end
      end
      qrbv_pkg::S_RD_ISSUE: begin
        if (sts.pos_ok) begin
          cmd.rd_pos = 1'b1;
          state_next = qrbv_pkg::S_RD_DATA;
        end else begin
          stat_next  = qrbv_pkg::ST_BEYOND;
          state_next = qrbv_pkg::S_RESP;
        end
      end
      qrbv_pkg::S_RD_DATA: begin
        use_rd_next = 1'b1;
        state_next  = qrbv_pkg::S_RESP;
      end
      qrbv_pkg::S_RESP: begin
        // hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          res.load   = 1'b1;
          state_next = qrbv_pkg::S_IDLE;
        end
      end
      default: state_next = qrbv_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ dv/tb_queue_remove_by_value_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_queue_remove_by_value_core
// Self-checking bench for the ordered queue with remove-by-value. Requests
// are driven through directed cases, a full-queue pass, a backpressure pass
// and random traffic under three idling profiles. A shadow copy of the queue
// predicts every response word, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_queue_remove_by_value_core;
  import qrbv_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE_LEN = 2 * DEPTH + 8;
  localparam int QUIET_MAX  = 8 * (HOLD_LEN + SETTLE_LEN);

  // the fourth action code carries no meaning
  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;

  typedef struct {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] entry_count;
    status_t          status;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst;

  qrbv_in_if  req_if ();
  qrbv_out_if rsp_if ();

  queue_remove_by_value_core #(.DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [VAL_W-1:0] queue_image[$];
  rsp_word_t        pending_rsp[$];
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  int               hold_request = 0;
  int               mismatches   = 0;
  int               quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the shadow queue and return the word it should give.
  function automatic rsp_word_t apply_request(logic [ACT_W-1:0] action,
                                              logic [VAL_W-1:0] value,
                                              logic [POS_W-1:0] position);
    rsp_word_t w;
    int        hit;
    w.read_value = '0;
    w.status     = ST_OK;
    hit          = -1;
    case (action)
      ACT_APPEND: begin
        if (queue_image.size() < DEPTH) queue_image.push_back(value);
        else w.status = ST_FULL;
      end
      ACT_REMOVE: begin
        foreach (queue_image[i]) begin
          if (hit < 0 && queue_image[i] == value) hit = i;
        end
        if (hit >= 0) queue_image.delete(hit);
        else w.status = ST_NOTFOUND;
      end
      ACT_READ: begin
        if (position < queue_image.size()) w.read_value = queue_image[position];
        else w.status = ST_BEYOND;
      end
      default: ;
    endcase
    w.entry_count = CNT_W'(queue_image.size());
    return w;
  endfunction

  function automatic void log_fault(string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endfunction

  // Bias towards a small pool so that duplicates occur.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1:    return VAL_W'($urandom_range(7));
      2:       return $urandom_range(1) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  // Called and returning just after a falling edge; valid stays high on return.
  task automatic send_request(logic [ACT_W-1:0] action, logic [VAL_W-1:0] value,
                              logic [POS_W-1:0] position);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= action;
    req_if.value    <= value;
    req_if.position <= position;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_rsp.push_back(apply_request(action, value, position));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic test_empty_queue();
    send_request(ACT_READ, '0, '0);
    send_request(ACT_REMOVE, '0, '0);
    send_request(ACT_IGNORED, '1, '1);
    send_request(ACT_APPEND, '1, '0);
    send_request(ACT_READ, '0, '0);
    send_request(ACT_REMOVE, '1, '0);
    send_request(ACT_READ, '0, '0);
  endtask

  task automatic test_remove_order();
    send_request(ACT_APPEND, 32'h0000_0000, '0);
    send_request(ACT_APPEND, 32'h5A5A_5A5A, '0);
    send_request(ACT_APPEND, 32'h0000_0007, '0);
    send_request(ACT_APPEND, 32'h5A5A_5A5A, '0);
    send_request(ACT_APPEND, 32'h8000_0001, '0);
    // first of two duplicates goes; the later one must move up
    send_request(ACT_REMOVE, 32'h5A5A_5A5A, '0);
    send_request(ACT_READ, '0, 6'd2);
    send_request(ACT_READ, '0, 6'd1);
    send_request(ACT_REMOVE, 32'h0000_0000, '0);
    send_request(ACT_REMOVE, 32'h8000_0001, '0);
    send_request(ACT_REMOVE, 32'h1234_5678, '0);
    send_request(ACT_READ, '0, '1);
    send_request(ACT_IGNORED, 32'h0000_0007, 6'd1);
    send_request(ACT_REMOVE, 32'h0000_0007, '0);
    send_request(ACT_REMOVE, 32'h5A5A_5A5A, '0);
  endtask

  task automatic test_full_queue();
    while (queue_image.size() < DEPTH) send_request(ACT_APPEND, $urandom, POS_W'($urandom));
    send_request(ACT_APPEND, '0, '0);
    send_request(ACT_READ, '0, '1);
    send_request(ACT_READ, '0, '0);
    send_request(ACT_REMOVE, queue_image[DEPTH / 2], '0);
    send_request(ACT_APPEND, '1, '0);
    send_request(ACT_APPEND, '1, '0);
    send_request(ACT_REMOVE, queue_image[DEPTH - 1], '0);
  endtask

  // Hold the response side off long enough that the request side stalls.
  task automatic test_backpressure();
    hold_request = HOLD_LEN;
    repeat (8) begin
      if ($urandom_range(1)) send_request(ACT_APPEND, pick_value(), POS_W'($urandom));
      else send_request(ACT_READ, $urandom, POS_W'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(int n_items, int src_pct, int snk_pct);
    int               target;
    int               sent;
    int               r;
    logic [POS_W-1:0] pos;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    target       = $urandom_range(DEPTH);
    sent         = 0;
    while (sent < n_items) begin
      if ($urandom_range(39) == 0) target = $urandom_range(3) ? $urandom_range(DEPTH) : DEPTH;
      r = $urandom_range(99);
      if (r < 4) begin
        send_request(ACT_IGNORED, $urandom, POS_W'($urandom));
      end else begin
        sent++;
        if (r < 30) begin
          if (queue_image.size() > 0 && $urandom_range(4) != 0)
            pos = POS_W'($urandom_range(queue_image.size() - 1));
          else
            pos = POS_W'($urandom);
          send_request(ACT_READ, $urandom, pos);
        end else if ((queue_image.size() < target) ? ($urandom_range(99) < 80)
                                                   : ($urandom_range(99) < 20)) begin
          send_request(ACT_APPEND, pick_value(), POS_W'($urandom));
        end else if (queue_image.size() > 0 && $urandom_range(9) < 7) begin
          send_request(ACT_REMOVE, queue_image[$urandom_range(queue_image.size() - 1)],
                       POS_W'($urandom));
        end else begin
          send_request(ACT_REMOVE, pick_value(), POS_W'($urandom));
        end
      end
    end
  endtask

  // response side: random stalls, or a counted hold-off when one is asked for
  initial begin
    int hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        log_fault($sformatf("response word with none expected: value %h count %0d status %0d",
                            rsp_if.read_value, rsp_if.entry_count, rsp_if.status));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.read_value !== want.read_value || rsp_if.entry_count !== want.entry_count ||
            rsp_if.status !== want.status) begin
          log_fault($sformatf({"response mismatch: expected value %h count %0d status %s, ",
                               "got value %h count %0d status %0d"},
                              want.read_value, want.entry_count, want.status.name(),
                              rsp_if.read_value, rsp_if.entry_count, rsp_if.status));
        end
      end
    end
  end

  // watchdog: end the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("tb_queue_remove_by_value_core: errors");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.action   = ACT_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 19;
    snk_idle_pct = 73;
    test_empty_queue();
    test_remove_order();
    test_full_queue();
    test_random_traffic(180, 19, 73);

    src_idle_pct = 73;
    snk_idle_pct = 19;
    test_backpressure();
    test_random_traffic(230, 73, 19);

    test_random_traffic(240, 0, 0);

    wait_drained();
    repeat (SETTLE_LEN) @(negedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb_queue_remove_by_value_core: clean");
    end else begin
      $display("tb_queue_remove_by_value_core: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/qrbv_pkg.sv
rtl/core/qrbv_in_if.sv
rtl/core/qrbv_out_if.sv
rtl/core/qrbv_ram.sv
rtl/core/qrbv_datapath.sv
rtl/core/qrbv_ctrl.sv
rtl/core/queue_remove_by_value_core.sv
dv/tb_queue_remove_by_value_core.sv
